// ===== hw/rtl/mtkd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mtkd_pkg;

    // symbol codes on the key input
    localparam logic [3:0] KEY_SPACE = 4'd0;
    localparam logic [3:0] KEY_SHIFT = 4'd1;
    localparam logic [3:0] KEY_SEP   = 4'd10;

    localparam logic [7:0] ASCII_SPACE   = 8'h20;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] CASE_GAP      = 8'h20;

    // result queue depth; a symbol is taken only while two entries are free
    localparam int unsigned OUTQ_DEPTH = 4;

    typedef struct packed {
        logic [7:0] out_char;
        logic       final_of_item;
    } t_result;

    // results produced by one symbol, in output order
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

    // offset of the key's first letter from 'a'
    function automatic logic [4:0] group_base(input logic [3:0] key);
        logic [4:0] base;
        unique case (key)
            4'd3:    base = 5'd3;
            4'd4:    base = 5'd6;
            4'd5:    base = 5'd9;
            4'd6:    base = 5'd12;
            4'd7:    base = 5'd15;
            4'd8:    base = 5'd19;
            4'd9:    base = 5'd22;
            default: base = 5'd0;
        endcase
        return base;
    endfunction

    // letters on the key
    function automatic logic [2:0] group_size(input logic [3:0] key);
        logic [2:0] size;
        unique case (key)
            4'd7, 4'd9: size = 3'd4;
            default:    size = 3'd3;
        endcase
        return size;
    endfunction

    // ascii letter for key, tap count and case
    function automatic logic [7:0] letter_char(input logic [3:0] key,
                                               input logic [1:0] tap,
                                               input logic       upper);
        logic [7:0] ch;
        ch = ASCII_LOWER_A + {3'd0, group_base(key)} + {6'd0, tap};
        if (upper) begin
            ch = ch - CASE_GAP;
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mtkd_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mtkd_decode
    import mtkd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_advance,
    input  wire logic [3:0] i_key,
    input  wire logic       i_last,
    output t_push           o_push
);

    logic       r_held_valid;
    logic [3:0] r_held_key;
    logic [1:0] r_tap;
    logic       r_held_upper;
    logic       r_shift;

    logic       n_held_valid;
    logic [3:0] n_held_key;
    logic [1:0] n_tap;
    logic       n_held_upper;
    logic       n_shift;

    logic       is_letter;
    logic       flush_a;
    logic       emit_space;
    logic       flush_b;
    logic [7:0] char_a;
    logic [7:0] char_b;
    logic [2:0] tap_inc;
    logic [1:0] n_count;

    // symbol handling, then end-of-message flush
    always_comb begin
        is_letter  = (i_key >= 4'd2) && (i_key <= 4'd9);
        flush_a    = 1'b0;
        emit_space = 1'b0;
        char_a     = letter_char(r_held_key, r_tap, r_held_upper);
        tap_inc    = {1'b0, r_tap} + 3'd1;

        n_held_valid = r_held_valid;
        n_held_key   = r_held_key;
        n_tap        = r_tap;
        n_held_upper = r_held_upper;
        n_shift      = r_shift;

        if (is_letter) begin
            if (r_held_valid && (r_held_key == i_key)) begin
                n_tap = (tap_inc == group_size(i_key)) ? 2'd0 : tap_inc[1:0];
            end else begin
                flush_a      = r_held_valid;
                n_held_key   = i_key;
                n_tap        = 2'd0;
                n_held_valid = 1'b1;
                n_held_upper = r_shift;
                n_shift      = 1'b0;
            end
        end else if (i_key == KEY_SHIFT) begin
            flush_a = r_held_valid;
            n_shift = 1'b1;
        end else if (i_key == KEY_SPACE) begin
            flush_a    = r_held_valid;
            emit_space = 1'b1;
            n_shift    = 1'b0;
        end else if (i_key == KEY_SEP) begin
            flush_a = r_held_valid;
        end

        // a flushed letter leaves nothing held unless a new run starts
        if (flush_a && !is_letter) begin
            n_held_valid = 1'b0;
            n_held_upper = 1'b0;
            n_tap        = 2'd0;
        end

        char_b  = letter_char(n_held_key, n_tap, n_held_upper);
        flush_b = i_last && n_held_valid;
        if (i_last) begin
            n_held_valid = 1'b0;
            n_held_upper = 1'b0;
            n_tap        = 2'd0;
            n_shift      = 1'b0;
        end
    end

    // order results: held letter, space, flushed letter (at most two)
    always_comb begin
        n_count = {1'b0, flush_a} + {1'b0, emit_space} + {1'b0, flush_b};
        o_push.count = i_advance ? n_count : 2'd0;
        o_push.res0.out_char      = flush_a ? char_a : (emit_space ? ASCII_SPACE : char_b);
        o_push.res0.final_of_item = (n_count == 2'd1);
        o_push.res1.out_char      = (emit_space && !flush_b) ? ASCII_SPACE : char_b;
        o_push.res1.final_of_item = 1'b1;
    end

    // held-letter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_held_key   <= 4'd0;
            r_tap        <= 2'd0;
            r_held_upper <= 1'b0;
            r_shift      <= 1'b0;
        end else if (i_advance) begin
            r_held_valid <= n_held_valid;
            r_held_key   <= n_held_key;
            r_tap        <= n_tap;
            r_held_upper <= n_held_upper;
            r_shift      <= n_shift;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mtkd_outq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mtkd_outq
    import mtkd_pkg::*;
#(
    parameter int unsigned DEPTH = OUTQ_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_push      i_push,
    output logic            o_room,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_char,
    output logic            o_final_of_item
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_result            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    logic               pop;
    logic [PTR_W-1:0]   wr_ptr_1;
    logic [PTR_W-1:0]   rd_ptr_1;

    // room for a full pair of results
    assign o_room      = (r_count <= CNT_W'(DEPTH - 2));
    assign o_out_valid = (r_count != '0);
    assign pop         = o_out_valid && !i_out_stall;
    assign wr_ptr_1    = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign rd_ptr_1    = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    assign o_out_char      = r_mem[r_rd_ptr].out_char;
    assign o_final_of_item = r_mem[r_rd_ptr].final_of_item;

    // result storage
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_ptr_1] <= i_push.res1;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.count == 2'd1) begin
                r_wr_ptr <= wr_ptr_1;
            end else if (i_push.count == 2'd2) begin
                r_wr_ptr <= (wr_ptr_1 == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_1 + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= rd_ptr_1;
            end
            r_count <= r_count + CNT_W'(i_push.count) - CNT_W'(pop);
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/multi_tap_keypad_decoder.sv =====
// multi-tap keypad text decoder
//
// input channel: i_in_valid / o_in_stall carry one keypad symbol word
// (i_key_symbol 0-9, 10 for the separator; i_last_symbol marks the end of
// a message). output channel: o_out_valid / i_out_stall carry one ascii
// character word (o_out_char) with o_final_of_item set on the last
// character caused by a symbol. a symbol yields zero, one or two words.
//
// order: a taken symbol sits in the input register, is decoded from there,
// and its characters are written into the result queue, whose head word is
// shown on the output. throughput: one symbol per cycle while the queue has
// room for a full pair; the output port drains one character a cycle while
// the receiver does not stall. the result queue, four entries by default,
// holds the characters that wait to be drained.
//
// reset (synchronous, active low) empties the queue and clears the held
// letter and pending shift. when the receiver stalls, the queue fills and
// o_in_stall rises once fewer than two free entries remain; the shown
// word holds until taken.
`timescale 1ns / 1ps
`default_nettype none

module multi_tap_keypad_decoder
    import mtkd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = OUTQ_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [3:0] i_key_symbol,
    input  wire logic       i_last_symbol,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_char,
    output logic            o_final_of_item
);

    logic       r_in_valid;
    logic [3:0] r_in_key;
    logic       r_in_last;

    logic       room;
    logic       advance;
    t_push      push;

    // input register moves on when the queue can take a full pair
    assign advance    = r_in_valid && room;
    assign o_in_stall = r_in_valid && !room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_key  <= i_key_symbol;
            r_in_last <= i_last_symbol;
        end
    end

    mtkd_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_key     (r_in_key),
        .i_last    (r_in_last),
        .o_push    (push)
    );

    mtkd_outq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_outq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .o_room          (room),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_char      (o_out_char),
        .o_final_of_item (o_final_of_item)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/mtkd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mtkd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_in_stall,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] o_out_char,
    input wire logic       o_final_of_item
);

    // nothing shown in the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid right after reset");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_out_char) && $stable(o_final_of_item))
        else $error("stalled output word changed");

    // a space always closes its symbol
    a_space_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_char == 8'h20) |-> o_final_of_item)
        else $error("space not marked final");

    // a non-final word is always a letter
    a_nonfinal_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_final_of_item |->
            ((o_out_char >= 8'h41) && (o_out_char <= 8'h5a)) ||
            ((o_out_char >= 8'h61) && (o_out_char <= 8'h7a)))
        else $error("non-final word is not a letter");

    // input only stalls while words wait at the output
    a_stall_backed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with nothing to send");

endmodule

bind multi_tap_keypad_decoder mtkd_checker u_mtkd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_out_char      (o_out_char),
    .o_final_of_item (o_final_of_item)
);

`default_nettype wire

// ===== bench/multi_tap_keypad_decoder_tb.sv =====
`timescale 1ns / 1ps

module multi_tap_keypad_decoder_tb;
    import mtkd_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int          RANDOM_WORDS = 650;
    localparam int          ROW_COUNT    = 28;
    // symbols above the separator are not keys
    localparam logic [3:0]  KEY_JUNK_LO  = 4'd11;
    localparam logic [3:0]  KEY_JUNK_HI  = 4'd15;

    // one directed stimulus row; n/c0/c1 only count where hand_typed is set
    typedef struct packed {
        logic [3:0] sym;
        logic       is_last;
        logic       hand_typed;
        logic [1:0] n;
        logic [7:0] c0;
        logic [7:0] c1;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic [3:0] i_key_symbol = 4'd0;
    logic       i_last_symbol = 1'b0;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_out_char;
    logic       o_final_of_item;

    // decoder state mirror
    logic [3:0] held_key = 4'd0;
    logic [1:0] tap_count = 2'd0;
    logic       held_valid = 1'b0;
    logic       held_upper = 1'b0;
    logic       shift_pending = 1'b0;

    // characters produced by the symbol being decoded
    logic [7:0] step_char [0:1];
    int         step_count;

    t_result     expected_chars [$];
    int          mismatch_count = 0;
    int unsigned cycle_count = 0;
    int          words_sent = 0;
    logic        quiet_stretch = 1'b0;
    logic        long_hold_req = 1'b0;
    t_row        directed_rows [ROW_COUNT];

    multi_tap_keypad_decoder DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_key_symbol    (i_key_symbol),
        .i_last_symbol   (i_last_symbol),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_char      (o_out_char),
        .o_final_of_item (o_final_of_item)
    );

    always #1 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [7:0] first_letter(input logic [3:0] key);
        case (key)
            4'd3:    return "d";
            4'd4:    return "g";
            4'd5:    return "j";
            4'd6:    return "m";
            4'd7:    return "p";
            4'd8:    return "t";
            4'd9:    return "w";
            default: return "a";
        endcase
    endfunction

    function automatic int letters_on_key(input logic [3:0] key);
        return (key == 4'd7 || key == 4'd9) ? 4 : 3;
    endfunction

    // emit the held letter, if any
    function automatic void flush_letter();
        logic [7:0] ch;
        if (!held_valid) return;
        ch = first_letter(held_key) + {6'd0, tap_count};
        if (held_upper) ch = ch - CASE_GAP;
        step_char[step_count] = ch;
        step_count = step_count + 1;
        held_valid = 1'b0;
        held_upper = 1'b0;
        tap_count  = 2'd0;
    endfunction

    // advance the state mirror by one symbol, filling step_char
    function automatic void decode_symbol(input logic [3:0] sym, input logic is_last);
        int next_tap;
        step_count = 0;
        if (sym >= 4'd2 && sym <= 4'd9) begin
            if (held_valid && held_key == sym) begin
                next_tap = tap_count + 1;
                if (next_tap >= letters_on_key(sym)) next_tap = 0;
                tap_count = next_tap[1:0];
            end else begin
                flush_letter();
                held_key      = sym;
                tap_count     = 2'd0;
                held_valid    = 1'b1;
                held_upper    = shift_pending;
                shift_pending = 1'b0;
            end
        end else if (sym == KEY_SHIFT) begin
            flush_letter();
            shift_pending = 1'b1;
        end else if (sym == KEY_SPACE) begin
            flush_letter();
            step_char[step_count] = ASCII_SPACE;
            step_count = step_count + 1;
            shift_pending = 1'b0;
        end else if (sym == KEY_SEP) begin
            flush_letter();
        end
        if (is_last) begin
            flush_letter();
            shift_pending = 1'b0;
        end
    endfunction

    // offer one word, wait for it to be taken, then queue its characters
    task automatic send_symbol(input t_row row);
        t_result r;
        int i;
        while (!quiet_stretch && $urandom_range(99) < 27) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_key_symbol  <= row.sym;
        i_last_symbol <= row.is_last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        decode_symbol(row.sym, row.is_last);
        if (row.hand_typed) begin
            for (i = 0; i < row.n; i++) begin
                r.out_char      = (i == 0) ? row.c0 : row.c1;
                r.final_of_item = (i == row.n - 1);
                expected_chars.push_back(r);
            end
        end else begin
            for (i = 0; i < step_count; i++) begin
                r.out_char      = step_char[i];
                r.final_of_item = (i == step_count - 1);
                expected_chars.push_back(r);
            end
        end
        words_sent = words_sent + 1;
    endtask

    // receiver: random stalls, one long hold-off on request
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_out_stall <= 1'b1;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left = 80;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !quiet_stretch && ($urandom_range(99) < 27);
            end
        end
    end

    // output word check
    always @(posedge i_clk) begin : char_checker
        t_result want;
        t_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.out_char      = o_out_char;
            got.final_of_item = o_final_of_item;
            if (expected_chars.size() == 0) begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= 10)
                    $display("ERROR: unexpected word char=%h final=%b",
                             got.out_char, got.final_of_item);
            end else begin
                want = expected_chars.pop_front();
                if (want !== got) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("ERROR: char exp=%h got=%h  final exp=%b got=%b",
                                 want.out_char, got.out_char,
                                 want.final_of_item, got.final_of_item);
                end
            end
        end
    end

    // stimulus
    initial begin : stimulus
        t_row row;
        int i;
        int choice;
        int run_len;
        logic [3:0] key;
        logic hold_asked;
        logic drain_done;

        directed_rows = '{
            // space right after reset
            '{KEY_SPACE,   1'b0, 1'b1, 2'd1, ASCII_SPACE, 8'h00},
            '{4'd2,        1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
            // tap count wraps on a three-letter key
            '{4'd2,        1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
            '{4'd2,        1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
            '{4'd2,        1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
            '{4'd3,        1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
            // repeated shift
            '{KEY_SHIFT,   1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
            '{KEY_SHIFT,   1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
            // upper case letter, four-letter key wraps
            '{4'd9,        1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
            '{4'd9,        1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
            '{4'd9,        1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
            '{4'd9,        1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
            '{4'd9,        1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
            '{KEY_SEP,     1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
            // shift survives a separator
            '{KEY_SHIFT,   1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
            '{KEY_SEP,     1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
            '{4'd7,        1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
            // shift then space: space stays plain
            '{KEY_SHIFT,   1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
            '{KEY_SPACE,   1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
            '{KEY_SPACE,   1'b0, 1'b1, 2'd1, ASCII_SPACE, 8'h00},
            // non-key symbols do not end a run
            '{4'd8,        1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
            '{KEY_JUNK_HI, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
            '{4'd8,        1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
            '{KEY_JUNK_LO, 1'b1, 1'b0, 2'd0, 8'h00, 8'h00},
            // end of message flushes the new letter
            '{4'd5,        1'b1, 1'b1, 2'd1, "j", 8'h00},
            '{KEY_SHIFT,   1'b1, 1'b1, 2'd0, 8'h00, 8'h00},
            '{4'd4,        1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
            // two words from one symbol
            '{KEY_SPACE,   1'b1, 1'b1, 2'd2, "g", ASCII_SPACE}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < ROW_COUNT; i++) send_symbol(directed_rows[i]);

        // random part: mostly letter runs, some control and junk symbols
        row = '0;
        hold_asked = 1'b0;
        drain_done = 1'b0;
        while (words_sent < ROW_COUNT + RANDOM_WORDS) begin
            quiet_stretch = (words_sent >= 180 && words_sent < 300);
            if (!hold_asked && words_sent >= 320) begin
                hold_asked    = 1'b1;
                long_hold_req = 1'b1;
            end
            if (!drain_done && words_sent >= 500) begin
                drain_done = 1'b1;
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (expected_chars.size() != 0) @(posedge i_clk);
            end
            choice  = $urandom_range(99);
            run_len = 1;
            if (choice < 60) begin
                key     = 4'($urandom_range(9, 2));
                run_len = $urandom_range(5, 1);
            end else if (choice < 70) begin
                key = KEY_SHIFT;
            end else if (choice < 80) begin
                key = KEY_SPACE;
            end else if (choice < 88) begin
                key = KEY_SEP;
            end else if (choice < 94) begin
                key = 4'($urandom_range(KEY_JUNK_HI, KEY_JUNK_LO));
            end else begin
                key = 4'($urandom_range(15, 0));
            end
            repeat (run_len) begin
                row.sym     = key;
                row.is_last = ($urandom_range(99) < 6);
                send_symbol(row);
            end
        end
        quiet_stretch = 1'b0;
        i_in_valid <= 1'b0;

        // drain, then watch for stray words
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/mtkd_pkg.sv
hw/rtl/mtkd_decode.sv
hw/rtl/mtkd_outq.sv
hw/rtl/multi_tap_keypad_decoder.sv
hw/rtl/mtkd_checker.sv
bench/multi_tap_keypad_decoder_tb.sv
